// ===== rtl/bea_pkg.sv =====
package bea_pkg;

    // field widths
    localparam int unsigned MV_W    = 12;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic [MV_W-1:0]    HIGH_THR_RESET   = 12'd170;
    localparam logic [MV_W-1:0]    LOW_THR_RESET    = 12'd150;
    localparam logic [COUNT_W-1:0] EVENTS_RESET     = 8'd5;
    localparam logic [HOLD_W-1:0]  HOLD_MS_RESET    = 16'd3000;

    // input word opcodes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HIGH_THR = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_EVENTS   = 2'd2,
        CFG_HOLD_MS  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        op_t             op;
        logic [MV_W-1:0] sample_mv;
    } in_word_t;

    typedef struct packed {
        logic               average_valid;
        logic [MV_W-1:0]    average_mv;
        logic               event_pulse;
        logic [COUNT_W-1:0] event_count;
        logic               alarm_on;
    } out_word_t;

    typedef struct packed {
        logic [MV_W-1:0]    high_threshold_mv;
        logic [MV_W-1:0]    low_threshold_mv;
        logic [COUNT_W-1:0] events_needed;
        logic [HOLD_W-1:0]  hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sample_sum;
        logic [INDEX_W-1:0] sample_index;
        logic [MV_W-1:0]    last_average;
        logic               armed_flag;
        logic [COUNT_W-1:0] events_seen;
        logic               alarm_active;
        logic [HOLD_W-1:0]  hold_elapsed;
    } state_t;

endpackage

// ===== rtl/bea_update.sv =====
module bea_update #(
    parameter int unsigned AVG_COUNT = 10
) (
    input  bea_pkg::state_t   st,
    input  bea_pkg::cfg_t     cfg,
    input  bea_pkg::in_word_t word,
    output bea_pkg::state_t   st_next,
    output bea_pkg::out_word_t res
);

    // exact reciprocal for any 16-bit sum: shift = 16 + ceil(log2 N)
    localparam int unsigned SHIFT   = bea_pkg::SUM_W + $clog2(AVG_COUNT);
    localparam int unsigned RECIP_W = bea_pkg::SUM_W + 1;
    localparam int unsigned PROD_W  = bea_pkg::SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + AVG_COUNT - 1) / AVG_COUNT);
    localparam logic [bea_pkg::INDEX_W:0] AVG_LAST = (bea_pkg::INDEX_W + 1)'(AVG_COUNT);

    logic [bea_pkg::SUM_W-1:0]   sum_add;
    logic [bea_pkg::INDEX_W:0]   index_inc;
    logic                        avg_done;
    logic [PROD_W-1:0]           product;
    logic [bea_pkg::MV_W-1:0]    avg_q;
    logic                        armed_up;
    logic                        count_hit;
    logic [bea_pkg::COUNT_W-1:0] events_upd;
    logic [bea_pkg::HOLD_W-1:0]  hold_inc;
    logic                        avg_pulse;
    logic                        evt_pulse;

    // accumulate and divide by the block length
    always_comb begin
        sum_add   = bea_pkg::SUM_W'({1'b0, st.sample_sum} + (bea_pkg::SUM_W + 1)'(word.sample_mv));
        index_inc = {1'b0, st.sample_index} + (bea_pkg::INDEX_W + 1)'(1);
        avg_done  = (index_inc >= AVG_LAST);
        product   = PROD_W'(sum_add) * PROD_W'(RECIP);
        avg_q     = product[SHIFT +: bea_pkg::MV_W];
    end

    // hysteresis detector: arm first, then test the fall
    always_comb begin
        armed_up   = st.armed_flag || (avg_q > cfg.high_threshold_mv);
        count_hit  = armed_up && (avg_q < cfg.low_threshold_mv);
        events_upd = st.events_seen;
        if (count_hit && (st.events_seen != '1)) begin
            events_upd = st.events_seen + bea_pkg::COUNT_W'(1);
        end
        hold_inc = st.hold_elapsed;
        if (st.hold_elapsed != '1) begin
            hold_inc = st.hold_elapsed + bea_pkg::HOLD_W'(1);
        end
    end

    // next state
    always_comb begin
        st_next   = st;
        avg_pulse = 1'b0;
        evt_pulse = 1'b0;
        if (word.op == bea_pkg::OP_SAMPLE) begin
            if (avg_done) begin
                st_next.last_average = avg_q;
                st_next.sample_sum   = '0;
                st_next.sample_index = '0;
                avg_pulse            = 1'b1;
                if (!st.alarm_active) begin
                    evt_pulse           = count_hit;
                    st_next.armed_flag  = armed_up && !count_hit;
                    st_next.events_seen = events_upd;
                    if (events_upd >= cfg.events_needed) begin
                        st_next.alarm_active = 1'b1;
                        st_next.hold_elapsed = '0;
                        // zero hold time clears in the same step
                        if (cfg.hold_ms == '0) begin
                            st_next.alarm_active = 1'b0;
                            st_next.events_seen  = '0;
                            st_next.armed_flag   = 1'b0;
                        end
                    end
                end
            end else begin
                st_next.sample_sum   = sum_add;
                st_next.sample_index = index_inc[bea_pkg::INDEX_W-1:0];
            end
        end else if (st.alarm_active) begin
            st_next.hold_elapsed = hold_inc;
            if (hold_inc >= cfg.hold_ms) begin
                st_next.alarm_active = 1'b0;
                st_next.events_seen  = '0;
                st_next.armed_flag   = 1'b0;
                st_next.hold_elapsed = '0;
            end
        end
    end

    // result word
    always_comb begin
        res.average_valid = avg_pulse;
        res.average_mv    = st_next.last_average;
        res.event_pulse   = evt_pulse;
        res.event_count   = st_next.events_seen;
        res.alarm_on      = st_next.alarm_active;
    end

endmodule

// ===== rtl/breath_event_alarm_unit.sv =====
// Each accepted input word is held in the input register, then moves into the result register.
// Throughput: one word per cycle while the result side is not stalled; input and result registers decouple
// the two channels, so a stalled result only stops intake once both are full.
// Reset (aresetn low, synchronous): configuration returns to its defaults,
// averaging, detector, event count and alarm timer clear, no word is held.
module breath_event_alarm_unit #(
    parameter int unsigned AVG_COUNT = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bea_pkg::in_word_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bea_pkg::out_word_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  bea_pkg::cfg_index_t              cfg_index,
    input  logic [bea_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bea_pkg::cfg_t      cfg_reg;
    bea_pkg::state_t    state_reg;
    bea_pkg::state_t    state_next;
    bea_pkg::in_word_t  in_word_reg;
    logic               in_valid_reg;
    bea_pkg::out_word_t out_word_reg;
    bea_pkg::out_word_t out_word_next;
    logic               out_valid_reg;
    logic               advance;

    // move a word on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_threshold_mv <= bea_pkg::HIGH_THR_RESET;
            cfg_reg.low_threshold_mv  <= bea_pkg::LOW_THR_RESET;
            cfg_reg.events_needed     <= bea_pkg::EVENTS_RESET;
            cfg_reg.hold_ms           <= bea_pkg::HOLD_MS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bea_pkg::CFG_HIGH_THR: begin
                    cfg_reg.high_threshold_mv <= cfg_data[bea_pkg::MV_W-1:0];
                end
                bea_pkg::CFG_LOW_THR: begin
                    cfg_reg.low_threshold_mv <= cfg_data[bea_pkg::MV_W-1:0];
                end
                bea_pkg::CFG_EVENTS: begin
                    cfg_reg.events_needed <= cfg_data[bea_pkg::COUNT_W-1:0];
                end
                bea_pkg::CFG_HOLD_MS: begin
                    cfg_reg.hold_ms <= cfg_data[bea_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // hold the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    bea_update #(
        .AVG_COUNT (AVG_COUNT)
    ) u_update (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .word    (in_word_reg),
        .st_next (state_next),
        .res     (out_word_next)
    );

    // advance the detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

`ifndef SYNTH
    // timer only runs while the alarm holds
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.alarm_active |-> (state_reg.hold_elapsed == '0))
        else $error("hold timer running with alarm off");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, state_reg.sample_index} < (bea_pkg::INDEX_W + 1)'(AVG_COUNT)))
        else $error("sample index beyond block length");

    a_pulse_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_pulse) |-> m_data.average_valid)
        else $error("event counted without a new average");

    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed word did not reach the result register");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> $stable(state_reg))
        else $error("state moved while the result side stalled");
`endif

endmodule
